// ===== src/xre_pkg.sv =====
// ----------------------------------------------------------------------------
// xre_pkg: shared types and constants of the reference expander
// Holds the front-to-back command format and the XML Char check.
// ----------------------------------------------------------------------------
`default_nettype none
package xre_pkg;

  localparam int unsigned CmdDepth = 4;

  // command from the front end: up to four data bytes plus optional done and error flag
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            done;
    logic            err;
  } xre_cmd_t;

  typedef enum logic [4:0] {
    PH_PLAIN = 5'b00001,
    PH_AMP   = 5'b00010,
    PH_HASH  = 5'b00100,
    PH_NUM   = 5'b01000,
    PH_NAME  = 5'b10000
  } xre_phase_t;

  localparam logic [7:0] RegAttrNormalize = 8'd0;
  localparam logic [7:0] RegReferencesOn  = 8'd1;

  function automatic logic is_xml_char(input logic [20:0] c);
    is_xml_char = (c == 21'h9) || (c == 21'hA) || (c == 21'hD)
               || (c >= 21'h20 && c <= 21'hD7FF)
               || (c >= 21'hE000 && c <= 21'hFFFD)
               || (c >= 21'h10000 && c <= 21'h10FFFF);
  endfunction

endpackage
`default_nettype wire

// ===== src/xml_reference_expander.sv =====
// each result is written into the four-entry command queue before it leaves
// throughput: one input byte per cycle while the queue has room; one output result per
// cycle while out_tready is high, the single output port draining the queue
// reset: synchronous active-low rst_n clears parse state and queue,
// attr_normalize to 0 and references_on to 1
// ----------------------------------------------------------------------------
// xml_reference_expander: XML text value UTF-8 check and reference expansion
// Front end decodes each byte, back end streams the resulting bytes.
// ----------------------------------------------------------------------------
`default_nettype none
module xml_reference_expander #(
  parameter int unsigned MAX_NAME_BYTES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // in_byte
  input  wire logic       in_tlast,   // is_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_byte
  output logic [3:0]      out_tuser,  // byte_valid, run_last, doc_done, syntax_error
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data     // bit 0 used
);
  import xre_pkg::*;

  logic     attr_r, refs_r;
  xre_cmd_t cmd;
  logic     in_xfer;

  assign cfg_ready = 1'b1;
  assign in_xfer = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= 1'b0; refs_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == RegAttrNormalize) attr_r <= cfg_data[0];
      if (cfg_index == RegReferencesOn)  refs_r <= cfg_data[0];
    end
  end

  xre_front #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_front (
    .clk, .rst_n, .in_valid(in_xfer), .in_byte(in_tdata), .in_last(in_tlast),
    .attr_normalize(attr_r), .references_on(refs_r), .cmd
  );

  xre_back u_back (
    .clk, .rst_n, .cmd_valid(in_tvalid), .cmd, .cmd_ready(in_tready),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

endmodule
`default_nettype wire

// ===== src/xre_front.sv =====
// ----------------------------------------------------------------------------
// xre_front: byte decoder
// Decodes UTF-8, tracks references and produces one command per input byte.
// ----------------------------------------------------------------------------
`default_nettype none
module xre_front #(
  parameter int unsigned MAX_NAME_BYTES = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  input  wire logic            attr_normalize,
  input  wire logic            references_on,
  output xre_pkg::xre_cmd_t    cmd
);
  import xre_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_NAME_BYTES + 1);

  xre_phase_t     phase_r, phase_nxt;
  logic [20:0]    pend_r, pend_nxt;
  logic [1:0]     extra_r, extra_nxt;
  logic [1:0]     rem_r, rem_nxt;
  logic [20:0]    refv_r, refv_nxt;
  logic           hex_r, hex_nxt;
  logic           hasd_r, hasd_nxt;
  logic [31:0]    name_r, name_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic           err_r, err_nxt;

  logic [20:0] cp;
  logic [20:0] min_cp;
  logic [20:0] enc_cp;
  logic        enc_en;
  logic [3:0]  dig;
  logic        dig_ok;
  logic [24:0] acc;
  logic [7:0]  ent;
  logic [7:0]  b;
  logic        hx;

  always_comb begin
    phase_nxt = phase_r; pend_nxt = pend_r; extra_nxt = extra_r; rem_nxt = rem_r;
    refv_nxt = refv_r; hex_nxt = hex_r; hasd_nxt = hasd_r; name_nxt = name_r;
    cnt_nxt = cnt_r; err_nxt = err_r;
    cmd = '0;
    enc_cp = '0; enc_en = 1'b0;
    b = in_byte;
    cp = {pend_r[14:0], in_byte[5:0]};
    case (extra_r)
      2'd1:    min_cp = 21'h80;
      2'd2:    min_cp = 21'h800;
      2'd3:    min_cp = 21'h10000;
      default: min_cp = 21'h0;
    endcase
    hx = hex_r && (phase_r != PH_HASH);
    dig = 4'd0; dig_ok = 1'b1;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) dig = 4'(in_byte - 8'h30);
    else if (hx && in_byte >= 8'h61 && in_byte <= 8'h66) dig = 4'(in_byte - 8'h57);
    else if (hx && in_byte >= 8'h41 && in_byte <= 8'h46) dig = 4'(in_byte - 8'h37);
    else dig_ok = 1'b0;
    acc = hx ? {refv_r, 4'b0} + 25'(dig)
             : {1'b0, refv_r, 3'b0} + {3'b0, refv_r, 1'b0} + 25'(dig);
    ent = 8'h00;
    if (cnt_r == CntW'(2) && name_r == 32'h0000_746C) ent = 8'h3C;
    if (cnt_r == CntW'(2) && name_r == 32'h0000_7467) ent = 8'h3E;
    if (cnt_r == CntW'(3) && name_r == 32'h0070_6D61) ent = 8'h26;
    if (cnt_r == CntW'(4) && name_r == 32'h736F_7061) ent = 8'h27;
    if (cnt_r == CntW'(4) && name_r == 32'h746F_7571) ent = 8'h22;

    if (!err_r) begin
      case (phase_r)
        PH_PLAIN: begin
          if (rem_r != 2'd0) begin
            if (in_byte[7:6] != 2'b10) err_nxt = 1'b1;
            else begin
              pend_nxt = cp;
              rem_nxt = rem_r - 2'd1;
              if (rem_r == 2'd1) begin
                pend_nxt = '0; extra_nxt = '0;
                if (cp < min_cp || !is_xml_char(cp)) err_nxt = 1'b1;
                else begin enc_cp = cp; enc_en = 1'b1; end
              end
            end
          end else if (in_byte == 8'h26 && references_on) begin
            phase_nxt = PH_AMP;
          end else if (in_byte < 8'h80) begin
            if (!is_xml_char({13'b0, in_byte})) err_nxt = 1'b1;
            else begin
              if (attr_normalize && (in_byte == 8'h09 || in_byte == 8'h0A
                                     || in_byte == 8'h0D)) b = 8'h20;
              cmd.bytes[0] = b; cmd.nbytes = 3'd1;
            end
          end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
            pend_nxt = {16'b0, in_byte[4:0]}; extra_nxt = 2'd1; rem_nxt = 2'd1;
          end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
            pend_nxt = {17'b0, in_byte[3:0]}; extra_nxt = 2'd2; rem_nxt = 2'd2;
          end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
            pend_nxt = {18'b0, in_byte[2:0]}; extra_nxt = 2'd3; rem_nxt = 2'd3;
          end else err_nxt = 1'b1;
        end
        PH_AMP: begin
          if (in_byte == 8'h23) phase_nxt = PH_HASH;
          else if (in_byte == 8'h3B) err_nxt = 1'b1;
          else begin
            phase_nxt = PH_NAME; name_nxt = {24'b0, in_byte}; cnt_nxt = CntW'(1);
          end
        end
        PH_NAME: begin
          if (in_byte != 8'h3B) begin
            if (cnt_r >= CntW'(MAX_NAME_BYTES)) err_nxt = 1'b1;
            else begin
              if (cnt_r < CntW'(4)) name_nxt[8*cnt_r[1:0] +: 8] = in_byte;
              cnt_nxt = cnt_r + CntW'(1);
            end
          end else begin
            phase_nxt = PH_PLAIN; name_nxt = '0; cnt_nxt = '0;
            if (ent == 8'h00) err_nxt = 1'b1;
            else begin cmd.bytes[0] = ent; cmd.nbytes = 3'd1; end
          end
        end
        default: begin
          // hash and digit phases; the hash phase starts with an empty value
          phase_nxt = PH_NUM;
          if (phase_r == PH_HASH && in_byte == 8'h78) begin
            refv_nxt = '0; hasd_nxt = 1'b0; hex_nxt = 1'b1;
          end else if (in_byte == 8'h3B) begin
            phase_nxt = PH_PLAIN; refv_nxt = '0; hasd_nxt = 1'b0; hex_nxt = 1'b0;
            if (phase_r == PH_HASH || !hasd_r || !is_xml_char(refv_r)) err_nxt = 1'b1;
            else begin enc_cp = refv_r; enc_en = 1'b1; end
          end else if (!dig_ok) begin
            err_nxt = 1'b1;
          end else begin
            if (phase_r == PH_HASH) begin
              refv_nxt = 21'(dig); hex_nxt = 1'b0; hasd_nxt = 1'b1;
            end else if (acc > 25'h10FFFF) err_nxt = 1'b1;
            else begin refv_nxt = acc[20:0]; hasd_nxt = 1'b1; end
          end
        end
      endcase
    end

    if (enc_en) begin
      if (enc_cp < 21'h80) begin
        cmd.bytes[0] = {1'b0, enc_cp[6:0]}; cmd.nbytes = 3'd1;
      end else if (enc_cp < 21'h800) begin
        cmd.bytes[0] = {3'b110, enc_cp[10:6]}; cmd.bytes[1] = {2'b10, enc_cp[5:0]};
        cmd.nbytes = 3'd2;
      end else if (enc_cp < 21'h10000) begin
        cmd.bytes[0] = {4'b1110, enc_cp[15:12]};
        cmd.bytes[1] = {2'b10, enc_cp[11:6]}; cmd.bytes[2] = {2'b10, enc_cp[5:0]};
        cmd.nbytes = 3'd3;
      end else begin
        cmd.bytes[0] = {5'b11110, enc_cp[20:18]};
        cmd.bytes[1] = {2'b10, enc_cp[17:12]};
        cmd.bytes[2] = {2'b10, enc_cp[11:6]}; cmd.bytes[3] = {2'b10, enc_cp[5:0]};
        cmd.nbytes = 3'd4;
      end
    end
    if (err_nxt) cmd.nbytes = 3'd0;
    if (in_last && (phase_nxt != PH_PLAIN || rem_nxt != 2'd0)) err_nxt = 1'b1;
    cmd.done = in_last;
    cmd.err = err_nxt;
    if (in_last) begin
      phase_nxt = PH_PLAIN; pend_nxt = '0; extra_nxt = '0; rem_nxt = '0;
      refv_nxt = '0; hex_nxt = 1'b0; hasd_nxt = 1'b0; name_nxt = '0;
      cnt_nxt = '0; err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN; pend_r <= '0; extra_r <= '0; rem_r <= '0;
      refv_r <= '0; hex_r <= 1'b0; hasd_r <= 1'b0; name_r <= '0;
      cnt_r <= '0; err_r <= 1'b0;
    end else if (in_valid) begin
      phase_r <= phase_nxt; pend_r <= pend_nxt; extra_r <= extra_nxt;
      rem_r <= rem_nxt; refv_r <= refv_nxt; hex_r <= hex_nxt; hasd_r <= hasd_nxt;
      name_r <= name_nxt; cnt_r <= cnt_nxt; err_r <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/xre_back.sv =====
// ----------------------------------------------------------------------------
// xre_back: command queue and result sequencer
// Buffers commands and emits their bytes and done result one per cycle while out_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none
module xre_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  input  xre_pkg::xre_cmd_t    cmd,
  output logic                 cmd_ready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,
  output logic [3:0]           out_tuser
);
  import xre_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);

  xre_cmd_t        q_r [CmdDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic [2:0]      idx_r;
  xre_cmd_t        head;
  logic            push, pop, last_res;
  logic [2:0]      total;

  assign head = q_r[rp_r];
  assign total = head.nbytes + {2'b0, head.done};
  assign cmd_ready = (cnt_r != (PtrW+1)'(CmdDepth));
  assign push = cmd_valid && cmd_ready && (cmd.nbytes != 3'd0 || cmd.done);
  assign out_tvalid = (cnt_r != '0);
  assign last_res = (idx_r + 3'd1 == total);
  assign pop = out_tvalid && out_tready && last_res;

  // tuser: byte_valid, run_last, doc_done, syntax_error
  always_comb begin
    if (idx_r < head.nbytes) begin
      out_tdata = head.bytes[idx_r[1:0]];
      out_tuser = {1'b0, 1'b0, last_res, 1'b1};
    end else begin
      out_tdata = 8'h00;
      out_tuser = {head.err, 1'b1, 1'b1, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; idx_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PtrW'(1);
      if (pop) begin
        rp_r <= rp_r + PtrW'(1); idx_r <= '0;
      end else if (out_tvalid && out_tready) idx_r <= idx_r + 3'd1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_xml_reference_expander.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xml_reference_expander: self-checking bench for the reference expander
// Feeds UTF-8 text values with entity and numeric references, predicts the
// output byte stream and status, and checks each transfer under random idling.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_xml_reference_expander;
  import xre_pkg::*;

  localparam int unsigned NameMax = 4;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       doc_done;
    logic       syntax_error;
  } exp_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_taken = 1'b0;

  xml_reference_expander #(.MAX_NAME_BYTES(NameMax)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic       p_attr;
  logic       p_refs;
  xre_phase_t p_phase;
  logic [22:0] p_pend;
  logic [1:0] p_remain;
  logic [20:0] p_refval;
  logic       p_hex;
  logic       p_hasdig;
  logic [31:0] p_name;
  logic [2:0] p_ncount;
  logic       p_err;

  src_byte_t pending_bytes[$];
  exp_out_t  expected_out[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off_cycles = 0;
  int        idle_cycles = 0;

  function automatic logic xml_char_ok(input logic [20:0] c);
    return c == 21'h9 || c == 21'hA || c == 21'hD
        || (c >= 21'h20 && c <= 21'hD7FF)
        || (c >= 21'hE000 && c <= 21'hFFFD)
        || (c >= 21'h10000 && c <= 21'h10FFFF);
  endfunction

  task automatic clear_parse_state();
    p_phase = PH_PLAIN; p_pend = '0; p_remain = '0; p_refval = '0;
    p_hex = 1'b0; p_hasdig = 1'b0; p_name = '0; p_ncount = '0; p_err = 1'b0;
  endtask

  // encode a code point as utf-8 into the output list
  task automatic emit_code_point(input logic [20:0] cp, inout logic [7:0] ob[$]);
    if (cp < 21'h80) ob.push_back(cp[7:0]);
    else if (cp < 21'h800) begin
      ob.push_back(8'hC0 | cp[10:6]); ob.push_back(8'h80 | cp[5:0]);
    end else if (cp < 21'h10000) begin
      ob.push_back(8'hE0 | cp[15:12]); ob.push_back(8'h80 | cp[11:6]);
      ob.push_back(8'h80 | cp[5:0]);
    end else begin
      ob.push_back(8'hF0 | cp[20:18]); ob.push_back(8'h80 | cp[17:12]);
      ob.push_back(8'h80 | cp[11:6]); ob.push_back(8'h80 | cp[5:0]);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, inout logic [7:0] ob[$]);
    logic [20:0] cp;
    logic [1:0]  extra;
    logic [20:0] min_cp;
    logic [4:0]  dig;
    logic [4:0]  base;
    logic [7:0]  ch;
    logic [7:0]  lit;
    case (p_phase)
      PH_PLAIN: begin
        if (p_remain != 0) begin
          if (b[7:6] != 2'b10) begin p_err = 1'b1; return; end
          cp = {p_pend[14:0], b[5:0]};
          extra = p_pend[22:21];
          p_pend = {extra, cp};
          p_remain--;
          if (p_remain != 0) return;
          p_pend = '0;
          min_cp = extra == 2'd1 ? 21'h80 : extra == 2'd2 ? 21'h800 : 21'h10000;
          if (cp < min_cp || !xml_char_ok(cp)) begin p_err = 1'b1; return; end
          emit_code_point(cp, ob);
        end else if (b == "&" && p_refs) p_phase = PH_AMP;
        else if (b < 8'h80) begin
          if (!xml_char_ok({13'd0, b})) begin p_err = 1'b1; return; end
          lit = (p_attr && (b == 8'h9 || b == 8'hA || b == 8'hD)) ? 8'h20 : b;
          ob.push_back(lit);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          p_pend = {2'd1, 16'd0, b[4:0]}; p_remain = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          p_pend = {2'd2, 17'd0, b[3:0]}; p_remain = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          p_pend = {2'd3, 18'd0, b[2:0]}; p_remain = 2'd3;
        end else p_err = 1'b1;
      end
      PH_AMP: begin
        if (b == "#") p_phase = PH_HASH;
        else if (b == ";") p_err = 1'b1;
        else begin p_phase = PH_NAME; p_name = {24'd0, b}; p_ncount = 3'd1; end
      end
      PH_NAME: begin
        if (b != ";") begin
          if (p_ncount >= NameMax) begin p_err = 1'b1; return; end
          p_name[8*p_ncount +: 8] = b;
          p_ncount++;
          return;
        end
        ch = 8'h00;
        if (p_ncount == 2 && p_name == {8'd0, 8'd0, "t", "l"}) ch = "<";
        if (p_ncount == 2 && p_name == {8'd0, 8'd0, "t", "g"}) ch = ">";
        if (p_ncount == 3 && p_name == {8'd0, "p", "m", "a"}) ch = "&";
        if (p_ncount == 4 && p_name == {"s", "o", "p", "a"}) ch = 8'h27;
        if (p_ncount == 4 && p_name == {"t", "o", "u", "q"}) ch = 8'h22;
        p_phase = PH_PLAIN; p_name = '0; p_ncount = '0;
        if (ch == 8'h00) p_err = 1'b1;
        else ob.push_back(ch);
      end
      default: begin
        if (p_phase == PH_HASH) begin
          p_phase = PH_NUM; p_refval = '0; p_hasdig = 1'b0; p_hex = 1'b0;
          if (b == "x") begin p_hex = 1'b1; return; end
        end
        base = p_hex ? 5'd16 : 5'd10;
        if (b == ";") begin
          cp = p_refval;
          p_phase = PH_PLAIN;
          if (!(p_hasdig && xml_char_ok(cp))) p_err = 1'b1;
          else emit_code_point(cp, ob);
          p_refval = '0; p_hasdig = 1'b0; p_hex = 1'b0;
          return;
        end
        if (b >= "0" && b <= "9") dig = 5'(b - "0");
        else if (p_hex && b >= "a" && b <= "f") dig = 5'(b - "a" + 8'd10);
        else if (p_hex && b >= "A" && b <= "F") dig = 5'(b - "A" + 8'd10);
        else begin p_err = 1'b1; return; end
        if (32'(p_refval) > (32'h10FFFF - dig) / base) begin p_err = 1'b1; return; end
        p_refval = 21'(32'(p_refval) * base + dig);
        p_hasdig = 1'b1;
      end
    endcase
  endtask

  task automatic predict_byte(input src_byte_t sb);
    logic [7:0] ob[$];
    int total;
    if (!p_err) decode_byte(sb.data, ob);
    if (p_err) ob.delete();
    if (sb.last && (p_phase != PH_PLAIN || p_remain != 0)) p_err = 1'b1;
    total = ob.size() + (sb.last ? 1 : 0);
    foreach (ob[k]) expected_out.push_back('{ob[k], 1'b1, k == total - 1, 1'b0, 1'b0});
    if (sb.last) begin
      expected_out.push_back('{8'h00, 1'b0, 1'b1, 1'b1, p_err});
      clear_parse_state();
    end
  endtask

  task automatic report_mismatch(input string what, input exp_out_t got, input exp_out_t want);
    $display("mismatch (%s) at %0t: got %h/%b%b%b%b want %h/%b%b%b%b", what, $realtime,
             got.data, got.byte_valid, got.run_last, got.doc_done, got.syntax_error,
             want.data, want.byte_valid, want.run_last, want.doc_done, want.syntax_error);
    fail_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && in_taken) begin
      predict_byte(pending_bytes.pop_front());
    end
    if (rst_n && pending_bytes.size() > 0 && (in_tvalid && !in_taken ||
        $urandom_range(99) >= send_idle_pct)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_bytes[0].data;
      in_tlast  <= pending_bytes[0].last;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver, with its own hold-off count
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && $urandom_range(99) >= recv_stall_pct;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    exp_out_t got;
    exp_out_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser[0], out_tuser[1], out_tuser[2], out_tuser[3]};
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected", got, got);
      end else begin
        want = expected_out.pop_front();
        if (got.byte_valid != want.byte_valid) report_mismatch("byte_valid", got, want);
        if (got.byte_valid && want.byte_valid && got.data != want.data)
          report_mismatch("out_byte", got, want);
        if (got.run_last != want.run_last) report_mismatch("run_last", got, want);
        if (got.doc_done != want.doc_done) report_mismatch("doc_done", got, want);
        if (got.syntax_error != want.syntax_error)
          report_mismatch("syntax_error", got, want);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || (pending_bytes.size() == 0 && expected_out.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_text(input string s, input logic end_value);
    for (int i = 0; i < s.len(); i++)
      pending_bytes.push_back('{s[i], end_value && i == s.len() - 1});
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_tvalid || expected_out.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= {7'd0, val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == RegAttrNormalize) p_attr = val; else p_refs = val;
  endtask

  // one random value: mostly well-formed pieces, some noise
  task automatic push_random_value();
    int pieces;
    logic [20:0] cp;
    logic [7:0] ob[$];
    pieces = $urandom_range(1, 6);
    for (int i = 0; i < pieces; i++) begin
      case ($urandom_range(9))
        0, 1: push_text(string'(8'($urandom_range(8'h20, 8'h7E))), 1'b0);
        2: push_text($urandom_range(1) ? "&lt;" : ($urandom_range(1) ? "&quot;" : "&apos;"), 1'b0);
        3: push_text($urandom_range(1) ? "&gt;" : "&amp;", 1'b0);
        4: push_text($sformatf("&#%0d;", $urandom_range(32, 70000)), 1'b0);
        5: push_text($sformatf("&#x%0h;", $urandom_range(0, 21'h10FFFF)), 1'b0);
        6: begin
          cp = $urandom_range(0, 21'h10FFFF);
          ob.delete();
          emit_code_point(cp, ob);
          foreach (ob[k]) pending_bytes.push_back('{ob[k], 1'b0});
        end
        7: push_text(string'(8'($urandom_range(0, 2) == 0 ? 8'h09 : 8'h0A)), 1'b0);
        8: pending_bytes.push_back('{8'($urandom_range(255)), 1'b0});
        default: push_text($urandom_range(1) ? "&X;" : "&#X1;", 1'b0);
      endcase
    end
    pending_bytes.push_back('{8'($urandom_range(8'h20, 8'h7E)), 1'b1});
  endtask

  task automatic random_phase(input int n_values, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_values; i++) push_random_value();
    wait_drained();
  endtask

  initial begin
    p_attr = 1'b0; p_refs = 1'b1;
    clear_parse_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, entities, numeric limits, bad utf-8, truncation
    push_text("a&lt;&gt;&amp;&apos;&quot;", 1'b1);
    push_text("&#1114111;&#x10FFFF;&#xD800;&#x110000;", 1'b1);
    pending_bytes.push_back('{8'hF4, 1'b0}); pending_bytes.push_back('{8'h8F, 1'b0});
    pending_bytes.push_back('{8'hBF, 1'b0}); pending_bytes.push_back('{8'hBF, 1'b1});
    pending_bytes.push_back('{8'hC0, 1'b0}); pending_bytes.push_back('{8'h80, 1'b1});
    pending_bytes.push_back('{8'hFF, 1'b1});
    pending_bytes.push_back('{8'h00, 1'b1});
    push_text("&#xaF;&#;&quots;&", 1'b1);
    wait_drained();

    write_reg(RegAttrNormalize, 1'b1);
    write_reg(RegReferencesOn, 1'b0);
    push_text("\t\n\r&#x9;&", 1'b1);
    random_phase(4, 0, 0);
    write_reg(RegReferencesOn, 1'b1);
    random_phase(4, 78, 0);
    write_reg(RegAttrNormalize, 1'b0);
    random_phase(4, 0, 78);
    random_phase(3, 18, 18);

    // long receiver hold-off while the sender keeps offering
    hold_off_cycles = 300;
    random_phase(3, 0, 0);
    hold_off_cycles = 0;
    random_phase(3, 0, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
